// ===== sv/gtp_pkg.sv =====
// Package for the GUID text parser: widths, position constants, character codes
// and the structs passed between modules. No dependencies.
`default_nettype none

package gtp_pkg;

   localparam int unsigned ChW      = 16;
   localparam int unsigned HalfW    = 64;
   localparam int unsigned NibW     = 4;
   localparam int unsigned TextLen  = 36;
   localparam int unsigned PosW     = $clog2(TextLen + 1);

   localparam logic [PosW-1:0] POS_DASH0 = PosW'(8);
   localparam logic [PosW-1:0] POS_DASH1 = PosW'(13);
   localparam logic [PosW-1:0] POS_DASH2 = PosW'(18);
   localparam logic [PosW-1:0] POS_DASH3 = PosW'(23);
   localparam logic [PosW-1:0] POS_LAST  = PosW'(TextLen - 1);
   localparam logic [PosW-1:0] POS_END   = PosW'(TextLen);

   localparam logic [ChW-1:0] CHAR_DASH  = 16'h002d;
   localparam logic [ChW-1:0] CHAR_ZERO  = 16'h0030;
   localparam logic [ChW-1:0] CHAR_NINE  = 16'h0039;
   localparam logic [ChW-1:0] CHAR_LO_A  = 16'h0061;
   localparam logic [ChW-1:0] CHAR_LO_F  = 16'h0066;
   localparam logic [ChW-1:0] CHAR_UP_A  = 16'h0041;
   localparam logic [ChW-1:0] CHAR_UP_F  = 16'h0046;
   localparam logic [NibW-1:0] NIB_TEN   = 4'ha;

   // classification of one character at one text position
   typedef struct packed {
      logic            past_end;  // position already at the full length
      logic            fits;      // character is what the slot wants
      logic            is_digit;  // slot is a digit slot and char is hex
      logic [NibW-1:0] nib;
   } gtp_class_type;

   typedef struct packed {
      logic             valid_res;
      logic [HalfW-1:0] guid_high;
      logic [HalfW-1:0] guid_low;
   } gtp_result_type;

endpackage

`default_nettype wire

// ===== sv/gtp_char_class.sv =====
// Character classifier: checks one character against its text position
// (dash slot or hex digit slot) and decodes the hex nibble. Uses gtp_pkg.
`default_nettype none

module gtp_char_class (
   input  wire logic [gtp_pkg::ChW-1:0]  ch,
   input  wire logic [gtp_pkg::PosW-1:0] pos,
   output gtp_pkg::gtp_class_type        cls
);
   import gtp_pkg::*;

   logic            dash_slot;
   logic            hex_ok;
   logic [NibW-1:0] nib;

   assign dash_slot = (pos == POS_DASH0) || (pos == POS_DASH1) ||
                      (pos == POS_DASH2) || (pos == POS_DASH3);

   always_comb begin
      hex_ok = 1'b1;
      nib    = '0;
      priority if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         nib = NibW'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
         nib = NibW'(ch - CHAR_LO_A) + NIB_TEN;
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
         nib = NibW'(ch - CHAR_UP_A) + NIB_TEN;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      cls.past_end = (pos == POS_END);
      cls.nib      = nib;
      cls.is_digit = !cls.past_end && !dash_slot && hex_ok;
      priority if (cls.past_end) begin
         cls.fits = 1'b0;
      end else if (dash_slot) begin
         cls.fits = (ch == CHAR_DASH);
      end else begin
         cls.fits = hex_ok;
      end
   end

endmodule

`default_nettype wire

// ===== sv/guid_text_parser_top.sv =====
// GUID text parser top level: per-character state update, result register
// with skid stage. Uses gtp_pkg and gtp_char_class.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_ch[15:0], req_last
//   rsp      out  rsp_valid/rsp_stall  rsp_valid_res, rsp_guid_high, rsp_guid_low
//
// One character per cycle while req_stall is low; position check and 4-bit shift
// are one level of logic. A last character's result is registered (output or skid).
// Reset is synchronous and clears position, error flag, accumulator and valids.
// A skid register holds one result while rsp is stalled; req stalls only
// when that skid register is full.
`default_nettype none

module guid_text_parser_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [gtp_pkg::ChW-1:0]    req_ch,
   input  wire logic                       req_last,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic                       rsp_valid_res,
   output      logic [gtp_pkg::HalfW-1:0]  rsp_guid_high,
   output      logic [gtp_pkg::HalfW-1:0]  rsp_guid_low
);
   import gtp_pkg::*;

   logic [PosW-1:0]    pos_ff, pos_in;
   logic               err_ff, err_in;
   logic [2*HalfW-1:0] acc_ff, acc_in;
   logic               out_valid_ff, out_valid_in;
   gtp_result_type     out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   gtp_result_type     skid_ff, skid_in;

   gtp_class_type      cls;
   gtp_result_type     res;
   logic               accept;
   logic               push;
   logic               out_take;
   logic               ok;
   logic               err_upd;
   logic [2*HalfW-1:0] acc_upd;

   gtp_char_class u_class (
      .ch  (req_ch),
      .pos (pos_ff),
      .cls (cls)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && req_last;

   assign err_upd = err_ff || !cls.fits;
   assign acc_upd = cls.is_digit ? {acc_ff[2*HalfW-NibW-1:0], cls.nib} : acc_ff;
   assign ok      = !err_upd && (pos_ff == POS_LAST);

   always_comb begin
      res.valid_res = ok;
      res.guid_high = ok ? acc_upd[2*HalfW-1:HalfW] : '0;
      res.guid_low  = ok ? acc_upd[HalfW-1:0] : '0;
   end

   // string state; a last character returns everything to the start
   always_comb begin
      pos_in = pos_ff;
      err_in = err_ff;
      acc_in = acc_ff;
      if (accept) begin
         if (req_last) begin
            pos_in = '0;
            err_in = 1'b0;
            acc_in = '0;
         end else begin
            pos_in = cls.past_end ? pos_ff : pos_ff + PosW'(1);
            err_in = err_upd;
            acc_in = acc_upd;
         end
      end
   end

   assign out_take = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         err_ff        <= 1'b0;
         acc_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         err_ff        <= err_in;
         acc_ff        <= acc_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_valid_res = out_ff.valid_res;
   assign rsp_guid_high = out_ff.guid_high;
   assign rsp_guid_low  = out_ff.guid_low;

endmodule

`default_nettype wire

// ===== sv/gtp_checker.sv =====
// Port-level checker for guid_text_parser_top, attached by bind.
// Uses gtp_pkg for field widths.
`default_nettype none

module gtp_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       req_last,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic                       rsp_valid_res,
   input wire logic [gtp_pkg::HalfW-1:0]  rsp_guid_high,
   input wire logic [gtp_pkg::HalfW-1:0]  rsp_guid_low
);
   import gtp_pkg::*;

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res) &&
         $stable(rsp_guid_high) && $stable(rsp_guid_low))
      else $error("stalled result changed");

   // a malformed string reports an all-zero value
   a_zero_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_guid_high == '0 && rsp_guid_low == '0)
      else $error("invalid result carries nonzero value");

   // a new result appears only after an accepted last character
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last))
      else $error("result without a last character");

endmodule

bind guid_text_parser_top gtp_checker u_gtp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_valid_res (rsp_valid_res),
   .rsp_guid_high (rsp_guid_high),
   .rsp_guid_low  (rsp_guid_low)
);

`default_nettype wire

// ===== verif/guid_text_parser_top_tb.sv =====
// Self-checking testbench for guid_text_parser_top: feeds GUID text one character
// per item and checks each string's result against a predictor kept in this file.
// Depends on gtp_pkg and the guid_text_parser_top RTL.
`timescale 1ns / 1ps

module guid_text_parser_top_tb;
   import gtp_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int ITEM_GOAL    = 1550;
   localparam int HOLD_START   = 300;
   localparam int HOLD_LEN     = 400;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [ChW-1:0] ch;
      logic           last;
   } text_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ChW-1:0]    req_ch = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_valid_res;
   logic [HalfW-1:0]  rsp_guid_high;
   logic [HalfW-1:0]  rsp_guid_low;

   guid_text_parser_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .rsp_guid_high (rsp_guid_high),
      .rsp_guid_low  (rsp_guid_low)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   text_item_type   pend_q[$];
   logic [ChW-1:0]  text_buf[$];
   gtp_result_type  guid_expect_q[$];
   int              total_items = 0;
   int              n_taken = 0;
   int              miss_cnt = 0;
   int              cycles = 0;
   int              hold_cnt = 0;
   logic            hold_on = 1'b0;
   logic            hold_done = 1'b0;
   logic            calm;

   // predictor state
   logic [PosW-1:0]  text_pos = '0;
   logic             text_bad = 1'b0;
   logic [HalfW-1:0] acc_hi = '0;
   logic [HalfW-1:0] acc_lo = '0;

   // no random idling on either side for a stretch in the middle of the run
   assign calm = (n_taken >= 700) && (n_taken < 1000);

   function automatic logic dash_slot(input int p);
      return p == POS_DASH0 || p == POS_DASH1 || p == POS_DASH2 || p == POS_DASH3;
   endfunction

   function automatic logic [ChW-1:0] hex_char(input logic [NibW-1:0] v, input logic up);
      if (v < NIB_TEN) return CHAR_ZERO + v;
      return (up ? CHAR_UP_A : CHAR_LO_A) + (v - NIB_TEN);
   endfunction

   // characters just outside the digit ranges, plus a few oddballs
   function automatic logic [ChW-1:0] near_miss(input int k);
      case (k)
         0: return 16'h002f;
         1: return 16'h003a;
         2: return 16'h0040;
         3: return 16'h0047;
         4: return 16'h0060;
         5: return 16'h0067;
         6: return 16'h0130;
         default: return 16'hffff;
      endcase
   endfunction

   task automatic parse_char(input logic [ChW-1:0] c, input logic fin);
      logic [PosW-1:0] p;
      logic [NibW-1:0] nib;
      logic            hex;
      logic            ok;
      gtp_result_type  r;
      p = text_pos;
      hex = 1'b1;
      nib = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) nib = NibW'(c - CHAR_ZERO);
      else if (c >= CHAR_LO_A && c <= CHAR_LO_F) nib = NIB_TEN + NibW'(c - CHAR_LO_A);
      else if (c >= CHAR_UP_A && c <= CHAR_UP_F) nib = NIB_TEN + NibW'(c - CHAR_UP_A);
      else hex = 1'b0;

      if (p >= POS_END) text_bad = 1'b1;
      else if (dash_slot(p)) begin
         if (c != CHAR_DASH) text_bad = 1'b1;
      end else if (!hex) text_bad = 1'b1;
      else {acc_hi, acc_lo} = {acc_hi[HalfW-NibW-1:0], acc_lo, nib};
      if (p < POS_END) text_pos = p + 1'b1;

      if (fin) begin
         ok = !text_bad && (p == POS_LAST);
         r.valid_res = ok;
         r.guid_high = ok ? acc_hi : '0;
         r.guid_low  = ok ? acc_lo : '0;
         guid_expect_q.push_back(r);
         text_pos = '0;
         text_bad = 1'b0;
         acc_hi = '0;
         acc_lo = '0;
      end
   endtask

   // well-formed text; digit < 0 picks random digits, letter_case 2 mixes cases
   task automatic build_guid(input int digit, input int letter_case);
      logic [NibW-1:0] v;
      logic            up;
      text_buf.delete();
      for (int i = 0; i < TextLen; i++) begin
         v = (digit < 0) ? NibW'($urandom_range(15)) : NibW'(digit);
         up = (letter_case == 2) ? 1'($urandom_range(1)) : 1'(letter_case);
         text_buf.push_back(dash_slot(i) ? CHAR_DASH : hex_char(v, up));
      end
   endtask

   task automatic flush_text();
      text_item_type t;
      for (int i = 0; i < text_buf.size(); i++) begin
         t.ch = text_buf[i];
         t.last = (i == text_buf.size() - 1);
         pend_q.push_back(t);
      end
      total_items += text_buf.size();
      text_buf.delete();
   endtask

   task automatic pick_digit_slot(output int p);
      p = $urandom_range(TextLen - 1);
      while (dash_slot(p)) p = $urandom_range(TextLen - 1);
   endtask

   task automatic note_miss(input string what, input gtp_result_type want);
      miss_cnt++;
      if (miss_cnt <= MAX_REPORTS)
         $display("%0t bad result (%s): want ok=%b %h_%h got ok=%b %h_%h", $realtime, what,
                  want.valid_res, want.guid_high, want.guid_low,
                  rsp_valid_res, rsp_guid_high, rsp_guid_low);
   endtask

   // driver: predicts each accepted item, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_ch, req_last);
            n_taken <= n_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
               req_valid <= 1'b1;
               req_ch    <= pend_q[0].ch;
               req_last  <= pend_q[0].last;
               pend_q.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the result skid fills and req backs up
   always @(posedge clock) begin
      if (!reset && !hold_done && n_taken >= HOLD_START) begin
         hold_cnt  <= hold_cnt + 1;
         hold_on   <= (hold_cnt != HOLD_LEN - 1);
         hold_done <= (hold_cnt == HOLD_LEN - 1);
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_on || (!calm && $urandom_range(99) < 18);
   end

   // monitor
   always @(posedge clock) begin
      gtp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (guid_expect_q.size() == 0) begin
            want = '0;
            note_miss("nothing expected", want);
         end else begin
            want = guid_expect_q.pop_front();
            if (rsp_valid_res !== want.valid_res || rsp_guid_high !== want.guid_high ||
                rsp_guid_low !== want.guid_low)
               note_miss("field differs", want);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("guid_text_parser_top: mismatch");
         $finish;
      end
   end

   initial begin
      int kind;
      int p;
      int n;

      // directed strings
      build_guid(0, 1);
      flush_text();
      build_guid(15, 1);
      flush_text();
      build_guid(15, 0);
      flush_text();
      build_guid(-1, 2);
      flush_text();
      build_guid(-1, 2);             // digit where a dash belongs
      text_buf[POS_DASH1] = CHAR_ZERO;
      flush_text();
      build_guid(-1, 2);             // dash where a digit belongs
      text_buf[0] = CHAR_DASH;
      flush_text();
      for (int k = 0; k < 8; k++) begin
         build_guid(-1, 2);
         pick_digit_slot(p);
         text_buf[p] = near_miss(k);
         flush_text();
      end
      text_buf.push_back(16'hffff);  // one-character string
      flush_text();
      build_guid(-1, 2);             // one short
      text_buf.delete(TextLen - 1);
      flush_text();
      build_guid(-1, 2);             // one long
      text_buf.push_back(CHAR_ZERO);
      flush_text();
      build_guid(-1, 2);             // far too long, position saturates
      repeat (30) text_buf.push_back(ChW'($urandom_range(16'hffff)));
      flush_text();

      while (total_items < ITEM_GOAL) begin
         kind = $urandom_range(99);
         build_guid(-1, 2);
         if (kind < 60) begin
         end else if (kind < 75) begin
            p = $urandom_range(TextLen - 1);
            if (dash_slot(p))
               text_buf[p] = $urandom_range(1) ? hex_char(NibW'($urandom_range(15)), 1'b1)
                                               : ChW'($urandom_range(16'hffff));
            else
               text_buf[p] = $urandom_range(1) ? near_miss($urandom_range(7))
                                               : ChW'($urandom_range(16'hffff));
         end else if (kind < 85) begin
            n = $urandom_range(TextLen - 1, 1);
            while (text_buf.size() > n) text_buf.delete(text_buf.size() - 1);
         end else if (kind < 93) begin
            repeat ($urandom_range(4, 1))
               text_buf.push_back($urandom_range(1) ? hex_char(NibW'($urandom_range(15)), 1'b0)
                                                    : ChW'($urandom_range(16'hffff)));
         end else begin
            text_buf.delete();
            repeat ($urandom_range(40, 1)) text_buf.push_back(ChW'($urandom_range(16'hffff)));
         end
         flush_text();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (n_taken != total_items) @(posedge clock);
      while (guid_expect_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (miss_cnt == 0)
         $display("guid_text_parser_top: match");
      else
         $display("guid_text_parser_top: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/gtp_pkg.sv
sv/gtp_char_class.sv
sv/guid_text_parser_top.sv
sv/gtp_checker.sv
verif/guid_text_parser_top_tb.sv
